FILE: design/qlr_pkg.sv
// ----------------------------------------------------------------------------
// qlr_pkg
// shared constants and types of the quadratic lagrange resampler
// ----------------------------------------------------------------------------
package qlr_pkg;

    localparam int IN_POINTS  = 128;
    localparam int OUT_POINTS = 64;
    localparam int AW         = $clog2(IN_POINTS);
    localparam int PW         = $clog2(OUT_POINTS);
    localparam int SMP_W      = 16;
    localparam int FREQ_W     = 15;
    localparam int FRAC_W     = 16;
    localparam int RATIO_W    = FREQ_W + FRAC_W;
    localparam int U_W        = RATIO_W + PW;
    localparam int N_W        = U_W - FRAC_W;
    localparam int T_W        = FRAC_W + 2;
    localparam int C_W        = 2 * FRAC_W + 4;
    localparam int P_W        = SMP_W + C_W;
    localparam int A_W        = P_W + 2;
    localparam int SH         = 2 * FRAC_W + 1;
    localparam int Y_W        = A_W - SH;
    localparam int DCNT_W     = $clog2(RATIO_W + 1);

    localparam logic [FREQ_W-1:0] NOM_RESET = FREQ_W'(5000);

    typedef logic signed [SMP_W-1:0] t_sample;
    typedef logic [FREQ_W-1:0]       t_freq;
    typedef logic [PW-1:0]           t_pos;

endpackage

FILE: design/qlr_if.sv
// ----------------------------------------------------------------------------
// qlr_in_if / qlr_out_if
// valid/ready channels for sample beats and resampled beats
// ----------------------------------------------------------------------------
interface qlr_in_if;
    import qlr_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    sample_last;
    t_freq   line_freq;
    modport source (output valid, sample, sample_last, line_freq, input ready);
    modport sink (input valid, sample, sample_last, line_freq, output ready);
endinterface

interface qlr_out_if;
    import qlr_pkg::*;
    logic    valid;
    logic    ready;
    t_sample resampled;
    t_pos    out_position;
    logic    out_last;
    logic    range_flag;
    modport source (output valid, resampled, out_position, out_last, range_flag,
                    input ready);
    modport sink (input valid, resampled, out_position, out_last, range_flag,
                  output ready);
endinterface

FILE: design/qlr_ram.sv
// ----------------------------------------------------------------------------
// qlr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module qlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/qlr_div.sv
// ----------------------------------------------------------------------------
// qlr_div
// restoring divider, one quotient bit per cycle, forms the q15.16 step ratio
// ----------------------------------------------------------------------------
module qlr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qlr_pkg::FREQ_W-1:0] i_num,
    input  logic [qlr_pkg::FREQ_W-1:0] i_den,
    output logic                       o_done,
    output logic [qlr_pkg::RATIO_W-1:0] o_quot
);
    import qlr_pkg::*;

    logic [RATIO_W-1:0] r_quot, n_quot;
    logic [FREQ_W:0]    r_rem, n_rem;
    logic [FREQ_W-1:0]  r_den;
    logic [DCNT_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [FREQ_W:0]    trial;
    logic               fits;

    // shift one dividend bit into the partial remainder
    always_comb begin
        trial  = {r_rem[FREQ_W-1:0], r_quot[RATIO_W-1]};
        fits   = trial >= {1'b0, r_den};
        n_rem  = fits ? trial - {1'b0, r_den} : trial;
        n_quot = {r_quot[RATIO_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(RATIO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= {i_num, {FRAC_W{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: design/quadratic_lagrange_resampler_top.sv
// ----------------------------------------------------------------------------
// quadratic_lagrange_resampler_top
// three point lagrange resampler tracking line frequency for one channel
// ----------------------------------------------------------------------------
// samples: one beat per cycle while idle, stored in the sample ram
// last sample: ratio division (none at zero line frequency), then per point:
//   decode, three read/multiply/accumulate rounds, load, beat
// a block of 64 points follows its last sample, held back by output stalls
// the block takes no sample beat until the last point has been taken
// synchronous active-low reset clears control state and sets nominal to 5000
module quadratic_lagrange_resampler_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [qlr_pkg::FREQ_W-1:0] i_cfg_wdata,
    qlr_in_if.sink                     i_smp,
    qlr_out_if.source                  o_res
);
    import qlr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_POS  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_MAC  = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_WAIT = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic [FREQ_W-1:0]     r_nom;
    logic [AW-1:0]         r_wptr;
    logic                  r_zero;
    logic [RATIO_W-1:0]    r_ratio;
    logic [U_W-1:0]        r_u;
    logic [PW-1:0]         r_idx;
    logic [1:0]            r_k;
    logic [AW-1:0]         r_base;
    logic [T_W-1:0]        r_t;
    logic                  r_flag;
    logic signed [C_W-1:0] r_coef;
    logic signed [P_W-1:0] r_prod;
    logic signed [A_W-1:0] r_acc;
    logic                  r_oval;
    t_sample               r_oval_y;
    logic                  r_olast;
    logic                  r_oflag;
    logic [PW-1:0]         r_opos;

    logic                  in_beat;
    logic                  out_beat;
    logic                  div_start;
    logic                  div_done;
    logic [RATIO_W-1:0]    div_quot;
    t_sample               rdata;
    logic [AW-1:0]         raddr;

    // position decode
    logic [N_W-1:0]        pos_n;
    logic [FRAC_W-1:0]     pos_f;
    logic                  clamp_lo;
    logic                  clamp_hi;
    logic [N_W-1:0]        base_full;
    logic [AW-1:0]         n_base;
    logic [T_W-1:0]        n_t;

    // coefficient and result
    logic signed [T_W:0]     ts, fa, fb;
    logic signed [2*T_W+1:0] ab;
    logic signed [C_W-1:0]   n_coef;
    logic signed [A_W-1:0]   acc_adj;
    logic signed [Y_W-1:0]   y_wide;
    t_sample                 y_sat;

    assign in_beat   = i_smp.valid && i_smp.ready;
    assign out_beat  = o_res.valid && o_res.ready;
    assign div_start = in_beat && i_smp.sample_last && (i_smp.line_freq != '0);

    qlr_ram #(
        .WIDTH (SMP_W),
        .DEPTH (IN_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_beat),
        .i_waddr (r_wptr),
        .i_wdata (i_smp.sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    qlr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_nom),
        .i_den   (i_smp.line_freq),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // base index and offset t from the position u
    always_comb begin
        pos_n     = r_u[U_W-1:FRAC_W];
        pos_f     = r_u[FRAC_W-1:0];
        clamp_lo  = (pos_n == '0) && !pos_f[FRAC_W-1];
        base_full = pos_f[FRAC_W-1] ? pos_n : pos_n - 1'b1;
        clamp_hi  = !clamp_lo && (base_full > N_W'(IN_POINTS - 3));
        if (clamp_hi) begin
            n_base = AW'(IN_POINTS - 3);
            n_t    = {2'b10, {FRAC_W{1'b0}}};
        end else if (clamp_lo) begin
            n_base = '0;
            n_t    = {2'b00, pos_f};
        end else begin
            n_base = base_full[AW-1:0];
            n_t    = pos_f[FRAC_W-1] ? {2'b00, pos_f} : {2'b01, pos_f};
        end
    end

    assign raddr = r_base + AW'(r_k);

    // lagrange weight for the sample being read, q33
    always_comb begin
        ts = signed'({1'b0, r_t});
        case (r_k)
            2'd0: begin
                fa = ts - (T_W+1)'(1 << FRAC_W);
                fb = ts - (T_W+1)'(2 << FRAC_W);
            end
            2'd1: begin
                fa = ts;
                fb = ts - (T_W+1)'(2 << FRAC_W);
            end
            default: begin
                fa = ts;
                fb = ts - (T_W+1)'(1 << FRAC_W);
            end
        endcase
        ab     = fa * fb;
        n_coef = (r_k == 2'd1) ? C_W'(-(ab <<< 1)) : C_W'(ab);
    end

    // divide by 2^33 toward zero, then saturate
    always_comb begin
        acc_adj = r_acc[A_W-1] ? r_acc + A_W'((64'd1 << SH) - 64'd1) : r_acc;
        y_wide  = acc_adj[A_W-1:SH];
        if (y_wide > Y_W'(32767)) begin
            y_sat = 16'sh7fff;
        end else if (y_wide < -Y_W'(32768)) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = SMP_W'(y_wide);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nom   <= NOM_RESET;
            r_wptr  <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nom <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (i_smp.sample_last) begin
                            r_wptr  <= '0;
                            r_state <= S_DIV;
                        end else if (r_wptr == AW'(IN_POINTS - 1)) begin
                            r_wptr <= '0;
                        end else begin
                            r_wptr <= r_wptr + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (r_zero || div_done) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: r_state <= S_RD;
                S_RD:  r_state <= S_MAC;
                S_MAC: r_state <= S_ACC;
                S_ACC: r_state <= (r_k == 2'd2) ? S_FIN : S_RD;
                S_FIN: begin
                    r_oval  <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_beat) begin
                        r_oval  <= 1'b0;
                        r_state <= r_olast ? S_IDLE : S_POS;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_beat && i_smp.sample_last) begin
            r_zero <= (i_smp.line_freq == '0);
        end
        if (r_state == S_DIV) begin
            r_ratio <= r_zero ? '0 : div_quot;
            r_u     <= '0;
            r_idx   <= '0;
        end
        if (r_state == S_POS) begin
            r_base <= n_base;
            r_t    <= n_t;
            // point 0 is sample 0 and only flags a zero frequency
            r_flag <= r_zero || ((r_idx != '0) && (clamp_lo || clamp_hi));
            r_k    <= '0;
            r_acc  <= '0;
        end
        if (r_state == S_RD) begin
            r_coef <= n_coef;
        end
        if (r_state == S_MAC) begin
            r_prod <= rdata * r_coef;
        end
        if (r_state == S_ACC) begin
            r_acc <= r_acc + A_W'(r_prod);
            r_k   <= r_k + 1'b1;
        end
        if (r_state == S_FIN) begin
            r_oval_y <= y_sat;
            r_opos   <= r_idx;
            r_olast  <= (r_idx == PW'(OUT_POINTS - 1));
            r_oflag  <= r_flag;
        end
        if ((r_state == S_WAIT) && out_beat) begin
            r_u   <= r_u + U_W'(r_ratio);
            r_idx <= r_idx + 1'b1;
        end
    end

    assign i_smp.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_oval;
    assign o_res.resampled    = r_oval_y;
    assign o_res.out_position = r_opos;
    assign o_res.out_last     = r_olast;
    assign o_res.range_flag   = r_oflag;

    // no sample beat is taken while a point waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_smp.ready && o_res.valid))
        else $error("sample beat accepted during output");

    // last flag only on the final point
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.out_last) |-> (o_res.out_position == PW'(OUT_POINTS - 1)))
        else $error("out_last on wrong point");

    // block end returns to loading
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_res.out_last) |=> i_smp.ready)
        else $error("not ready after last point");

    // write pointer restarts after the last sample
    a_wptr_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_smp.sample_last) |=> (r_wptr == '0))
        else $error("write pointer not cleared");

    // a point enters the output register only after all three taps
    a_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_k == 2'd3))
        else $error("point finished early");
endmodule
